// ===== sv/u16u8_pkg.sv =====
`timescale 1ns / 1ps
// types, constants and encoding functions shared by the transcoder modules
package u16u8_pkg;

   localparam logic [15:0] HIGH_FIRST         = 16'hD800;
   localparam logic [15:0] HIGH_LAST          = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST          = 16'hDC00;
   localparam logic [15:0] LOW_LAST           = 16'hDFFF;
   localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h010000;
   localparam logic [20:0] REPLACEMENT_CP     = 21'h00FFFD;

   localparam logic [7:0] LEAD2_MARK = 8'hC0;
   localparam logic [7:0] LEAD3_MARK = 8'hE0;
   localparam logic [7:0] LEAD4_MARK = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;

   localparam logic [1:0] LEN_ONE   = 2'd0;
   localparam logic [1:0] LEN_TWO   = 2'd1;
   localparam logic [1:0] LEN_THREE = 2'd2;
   localparam logic [1:0] LEN_FOUR  = 2'd3;

   // csr register indexes
   localparam logic REG_LITTLE_ENDIAN = 1'b0;

   // work for one input byte: up to two code points, or a bare end marker
   typedef struct packed {
      logic [1:0]  cp_count;
      logic [20:0] cp0;
      logic [20:0] cp1;
      logic        last;
   } item_type;

   // utf-8 length minus one
   function automatic logic [1:0] cp_len_m1(input logic [20:0] cp);
      logic [1:0] len;
      begin
         if (cp <= 21'h00007F) begin
            len = LEN_ONE;
         end else if (cp <= 21'h0007FF) begin
            len = LEN_TWO;
         end else if (cp <= 21'h00FFFF) begin
            len = LEN_THREE;
         end else begin
            len = LEN_FOUR;
         end
         return len;
      end
   endfunction

   function automatic logic [7:0] encode_byte(input logic [20:0] cp,
                                              input logic [1:0]  len_m1,
                                              input logic [1:0]  idx);
      logic [1:0] pos;
      logic [7:0] cont;
      logic [7:0] result;
      begin
         pos = len_m1 - idx;
         case (pos)
            2'd0:    cont = CONT_MARK | {2'b00, cp[5:0]};
            2'd1:    cont = CONT_MARK | {2'b00, cp[11:6]};
            2'd2:    cont = CONT_MARK | {2'b00, cp[17:12]};
            default: cont = CONT_MARK | {5'b00000, cp[20:18]};
         endcase
         if (idx != 2'd0) begin
            result = cont;
         end else begin
            case (len_m1)
               LEN_ONE:   result = cp[7:0];
               LEN_TWO:   result = LEAD2_MARK | {3'b000, cp[10:6]};
               LEN_THREE: result = LEAD3_MARK | {4'b0000, cp[15:12]};
               default:   result = LEAD4_MARK | {5'b00000, cp[20:18]};
            endcase
         end
         return result;
      end
   endfunction

endpackage

// ===== sv/u16u8_front.sv =====
`timescale 1ns / 1ps
// front end: pairs bytes into units, joins surrogates, queues code points
module u16u8_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   input  logic                little_endian,
   input  logic                queue_full,
   output logic                push,
   output u16u8_pkg::item_type push_item
);

   logic [7:0]  held_byte_ff, held_byte_in;
   logic        have_half_ff, have_half_in;
   logic [9:0]  pend_bits_ff, pend_bits_in;
   logic        have_pend_ff, have_pend_in;

   logic        accept;
   logic [15:0] unit;
   logic        is_high;
   logic        is_low;
   logic        s0, s1, s2;
   logic        pend_next;
   logic [20:0] join_cp;
   logic [20:0] v1;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      unit = little_endian ? {req_data_byte, held_byte_ff} : {held_byte_ff, req_data_byte};
      is_high = unit inside {[u16u8_pkg::HIGH_FIRST:u16u8_pkg::HIGH_LAST]};
      is_low  = unit inside {[u16u8_pkg::LOW_FIRST:u16u8_pkg::LOW_LAST]};
      join_cp = u16u8_pkg::SUPPLEMENTARY_BASE + {1'b0, pend_bits_ff, unit[9:0]};
      if (have_pend_ff && is_low) begin
         v1 = join_cp;
      end else if (is_low) begin
         v1 = u16u8_pkg::REPLACEMENT_CP;
      end else begin
         v1 = {5'b00000, unit};
      end
      s0 = have_half_ff && have_pend_ff && !is_low;
      s1 = have_half_ff && !is_high;
      pend_next = have_half_ff ? is_high : have_pend_ff;
      s2 = req_last_byte && pend_next;

      push_item.cp_count = {1'b0, s0} + {1'b0, s1} + {1'b0, s2};
      push_item.cp0 = (s0 || !s1) ? u16u8_pkg::REPLACEMENT_CP : v1;
      push_item.cp1 = (s0 && s1) ? v1 : u16u8_pkg::REPLACEMENT_CP;
      push_item.last = req_last_byte;
      push = accept && (s0 || s1 || s2 || req_last_byte);

      held_byte_in = held_byte_ff;
      have_half_in = have_half_ff;
      pend_bits_in = pend_bits_ff;
      have_pend_in = have_pend_ff;
      if (accept) begin
         if (have_half_ff) begin
            have_half_in = 1'b0;
            if (is_high) begin
               pend_bits_in = unit[9:0];
            end
         end else begin
            held_byte_in = req_data_byte;
            have_half_in = 1'b1;
         end
         have_pend_in = pend_next;
         if (req_last_byte) begin
            have_half_in = 1'b0;
            have_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
      pend_bits_ff <= pend_bits_in;
      if (reset) begin
         have_half_ff <= 1'b0;
         have_pend_ff <= 1'b0;
      end else begin
         have_half_ff <= have_half_in;
         have_pend_ff <= have_pend_in;
      end
   end

endmodule

// ===== sv/u16u8_queue.sv =====
`timescale 1ns / 1ps
// two-entry queue of work items between front and back
module u16u8_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  u16u8_pkg::item_type push_item,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output u16u8_pkg::item_type head_item
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   u16u8_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]      count_ff, count_in;

   assign full       = (count_ff == (PTR_W+1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/u16u8_back.sv =====
`timescale 1ns / 1ps
// back end: encodes queued code points into utf-8 bytes, one per cycle unless rsp_stall holds the output
module u16u8_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  u16u8_pkg::item_type head_item,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_last_of_run,
   output logic                rsp_end_of_text
);

   logic       cp_sel_ff, cp_sel_in;
   logic [1:0] byte_idx_ff, byte_idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       byte_valid_ff, byte_valid_in;
   logic       last_run_ff, last_run_in;
   logic       end_text_ff, end_text_in;

   logic [20:0] cur_cp;
   logic [1:0]  len_m1;
   logic        marker;
   logic        cp_done;
   logic        item_done;
   logic        out_free;
   logic        advance;

   always_comb begin
      cur_cp    = cp_sel_ff ? head_item.cp1 : head_item.cp0;
      len_m1    = u16u8_pkg::cp_len_m1(cur_cp);
      marker    = (head_item.cp_count == 2'd0);
      cp_done   = (byte_idx_ff == len_m1);
      item_done = marker || (cp_done && (cp_sel_ff == (head_item.cp_count == 2'd2)));
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = head_valid && out_free;
      pop       = advance && item_done;

      cp_sel_in   = cp_sel_ff;
      byte_idx_in = byte_idx_ff;
      if (advance) begin
         if (item_done) begin
            cp_sel_in   = 1'b0;
            byte_idx_in = 2'd0;
         end else if (cp_done) begin
            cp_sel_in   = 1'b1;
            byte_idx_in = 2'd0;
         end else begin
            byte_idx_in = byte_idx_ff + 2'd1;
         end
      end

      rsp_valid_in  = out_free ? head_valid : rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      last_run_in   = last_run_ff;
      end_text_in   = end_text_ff;
      if (advance) begin
         out_byte_in   = marker ? 8'h00 : u16u8_pkg::encode_byte(cur_cp, len_m1, byte_idx_ff);
         byte_valid_in = !marker;
         last_run_in   = item_done;
         end_text_in   = item_done && head_item.last;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      last_run_ff   <= last_run_in;
      end_text_ff   <= end_text_in;
      if (reset) begin
         cp_sel_ff    <= 1'b0;
         byte_idx_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cp_sel_ff    <= cp_sel_in;
         byte_idx_ff  <= byte_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_byte_valid  = byte_valid_ff;
   assign rsp_last_of_run = last_run_ff;
   assign rsp_end_of_text = end_text_ff;

endmodule

// ===== sv/utf16_to_utf8_transcoder_unit.sv =====
`timescale 1ns / 1ps
// top level of the utf-16 to utf-8 transcoder
//
// req channel: one utf-16 byte per transfer, req_last_byte marks the end of
// the text. rsp channel: one utf-8 byte per transfer; rsp_last_of_run marks
// the final result of an input byte, rsp_end_of_text the final result of the
// text, and a transfer with rsp_byte_valid low is a bare end marker.
// csr port: register 0 bit 0 selects little endian byte order (reset 1);
// write it only while the block is idle.
// the first result of an input byte passes through the queue entry and the
// output register. throughput: one input byte per cycle on the front end
// while the queue is not full, one result per cycle on the back end while the
// receiver does not stall; an input byte gives none to six utf-8 bytes, so the
// sustained rate is set by the back end's single byte per cycle.
// reset clears the pairing and surrogate state, the queue and the output
// register. when the receiver stalls, the output holds, the back end stops,
// the two-entry queue fills and req_stall rises.
module utf16_to_utf8_transcoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_text,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic little_endian_ff, little_endian_in;
   logic csr_write;

   logic                push;
   u16u8_pkg::item_type push_item;
   logic                pop;
   logic                queue_full;
   logic                head_valid;
   u16u8_pkg::item_type head_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      little_endian_in = little_endian_ff;
      if (csr_write && (csr_paddr[2] == u16u8_pkg::REG_LITTLE_ENDIAN)) begin
         little_endian_in = csr_pwdata[0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == u16u8_pkg::REG_LITTLE_ENDIAN) begin
         csr_prdata = {31'd0, little_endian_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         little_endian_ff <= 1'b1;
      end else begin
         little_endian_ff <= little_endian_in;
      end
   end

   u16u8_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .little_endian (little_endian_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_item     (push_item)
   );

   u16u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   u16u8_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_text (rsp_end_of_text)
   );

endmodule
